FILE: rtl/imubq_pkg.sv
// Shared types and constants for the six-axis IMU biquad low-pass block.
// Used by imubq_cfg, imubq_lane and the top level; no dependencies.
package imubq_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
  localparam int FILTERED_AXES  = 6;
  localparam int GROUP_AXES     = 3;
  localparam int NUM_AXES       = 9;
  localparam int CFG_DATA_BITS  = COEF_BITS;
  localparam int CFG_IDX_BITS   = 3;
  localparam int WARM_BITS      = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef struct packed {
    coef_t b0;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  typedef struct packed {
    coef_set_t              accel;
    coef_set_t              gyro;
    logic [1:0]             bypass;
    logic [WARM_BITS-1:0]   warmup_length;
  } cfg_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ACCEL_B0  = 3'd0,
    REG_ACCEL_A1  = 3'd1,
    REG_ACCEL_A2  = 3'd2,
    REG_GYRO_B0   = 3'd3,
    REG_GYRO_A1   = 3'd4,
    REG_GYRO_A2   = 3'd5,
    REG_BYPASS    = 3'd6,
    REG_WARMUP    = 3'd7
  } reg_idx_t;

  localparam int BYPASS_ACCEL = 0;
  localparam int BYPASS_GYRO  = 1;

endpackage

FILE: rtl/imu_six_axis_biquad_lowpass.sv
// Top level of the six-axis IMU biquad low-pass: input word register, six filter
// lanes, warm-up counter and result register. Depends on imubq_pkg, imubq_cfg, imubq_lane.
//
//   port group   direction  handshake            payload
//   in_*         in         in_valid/in_ready    accel_x..field_z, 16 bit signed
//   out_*        out        out_valid/out_ready  accel_x_out..field_z_out
//   cfg_*        in         cfg_we               cfg_index, cfg_data
//
// A word is taken every cycle while the result side does not stall.
// The six lanes compute combinationally from the input register into the result register.
// A stalled result holds the input register, which then drops in_ready.
// Reset and every config write clear filter history and the warm-up counter.
module imu_six_axis_biquad_lowpass (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  imubq_pkg::sample_t                   accel_x,
  input  imubq_pkg::sample_t                   accel_y,
  input  imubq_pkg::sample_t                   accel_z,
  input  imubq_pkg::sample_t                   rate_x,
  input  imubq_pkg::sample_t                   rate_y,
  input  imubq_pkg::sample_t                   rate_z,
  input  imubq_pkg::sample_t                   field_x,
  input  imubq_pkg::sample_t                   field_y,
  input  imubq_pkg::sample_t                   field_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output imubq_pkg::sample_t                   accel_x_out,
  output imubq_pkg::sample_t                   accel_y_out,
  output imubq_pkg::sample_t                   accel_z_out,
  output imubq_pkg::sample_t                   rate_x_out,
  output imubq_pkg::sample_t                   rate_y_out,
  output imubq_pkg::sample_t                   rate_z_out,
  output imubq_pkg::sample_t                   field_x_out,
  output imubq_pkg::sample_t                   field_y_out,
  output imubq_pkg::sample_t                   field_z_out,
  input  logic                                 cfg_we,
  input  logic [imubq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [imubq_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import imubq_pkg::*;

  cfg_t cfg;
  sample_t in_q  [NUM_AXES];
  sample_t out_q [NUM_AXES];
  sample_t lane_y [FILTERED_AXES];
  logic in_full;
  logic advance;
  logic warming;
  logic [WARM_BITS-1:0] warm_cnt;

  imubq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign warming  = warm_cnt < cfg.warmup_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q[0] <= accel_x;
      in_q[1] <= accel_y;
      in_q[2] <= accel_z;
      in_q[3] <= rate_x;
      in_q[4] <= rate_y;
      in_q[5] <= rate_z;
      in_q[6] <= field_x;
      in_q[7] <= field_y;
      in_q[8] <= field_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      warm_cnt <= '0;
    end else if (advance && warming) begin
      warm_cnt <= warm_cnt + WARM_BITS'(1);
    end
  end

  for (genvar i = 0; i < FILTERED_AXES; i++) begin : g_lane
    localparam int GRP = (i < GROUP_AXES) ? BYPASS_ACCEL : BYPASS_GYRO;
    coef_set_t lane_coef;
    logic      lane_pass;

    assign lane_coef = (GRP == BYPASS_ACCEL) ? cfg.accel : cfg.gyro;
    assign lane_pass = warming || cfg.bypass[GRP];

    imubq_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .clear   (cfg_we),
      .advance (advance),
      .pass    (lane_pass),
      .coef    (lane_coef),
      .x       (in_q[i]),
      .y       (lane_y[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < FILTERED_AXES; i++) begin
        out_q[i] <= lane_y[i];
      end
      for (int i = FILTERED_AXES; i < NUM_AXES; i++) begin
        out_q[i] <= in_q[i];
      end
    end
  end

  assign accel_x_out = out_q[0];
  assign accel_y_out = out_q[1];
  assign accel_z_out = out_q[2];
  assign rate_x_out  = out_q[3];
  assign rate_y_out  = out_q[4];
  assign rate_z_out  = out_q[5];
  assign field_x_out = out_q[6];
  assign field_y_out = out_q[7];
  assign field_z_out = out_q[8];

`ifndef NO_ASSERTIONS
  a_warm_bound: assert property (@(posedge clk) disable iff (rst)
    warm_cnt <= cfg.warmup_length)
    else $error("warm-up counter passed warm-up length");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> warm_cnt == '0)
    else $error("config write did not clear warm-up counter");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_full && out_valid && !out_ready))
    else $error("input held off without a stalled result");

  a_accel_bypass: assert property (@(posedge clk) disable iff (rst)
    (advance && cfg.bypass[BYPASS_ACCEL] && !cfg_we) |=> accel_x_out == $past(in_q[0]))
    else $error("bypassed accelerometer word changed");
`endif

endmodule

FILE: rtl/imubq_cfg.sv
// Configuration register file: coefficient sets, bypass mask, warm-up length.
// Depends on imubq_pkg.
module imubq_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [imubq_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [imubq_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output imubq_pkg::cfg_t                      cfg
);
  import imubq_pkg::*;

  cfg_t cfg_q;
  coef_t coef_in;

  assign coef_in = coef_t'(cfg_data[COEF_BITS-1:0]);
  assign cfg = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.accel         <= '0;
      cfg_q.gyro          <= '0;
      cfg_q.bypass        <= 2'b11;
      cfg_q.warmup_length <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ACCEL_B0: cfg_q.accel.b0 <= coef_in;
        REG_ACCEL_A1: cfg_q.accel.a1 <= coef_in;
        REG_ACCEL_A2: cfg_q.accel.a2 <= coef_in;
        REG_GYRO_B0:  cfg_q.gyro.b0  <= coef_in;
        REG_GYRO_A1:  cfg_q.gyro.a1  <= coef_in;
        REG_GYRO_A2:  cfg_q.gyro.a2  <= coef_in;
        REG_BYPASS:   cfg_q.bypass   <= cfg_data[1:0];
        REG_WARMUP:   cfg_q.warmup_length <= cfg_data[WARM_BITS-1:0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

endmodule

FILE: rtl/imubq_lane.sv
// One direct-form-1 biquad lane: history registers and the sum of products.
// Depends on imubq_pkg.
module imubq_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 advance,
  input  logic                 pass,
  input  imubq_pkg::coef_set_t coef,
  input  imubq_pkg::sample_t   x,
  output imubq_pkg::sample_t   y
);
  import imubq_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int ACC_W = SUM_W + COEF_BITS + 2;
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  sample_t x1, x2, y1, y2;

  logic signed [SUM_W-1:0] tap_sum;
  logic signed [ACC_W-1:0] b0_w, a1_w, a2_w, sum_w, y1_w, y2_w;
  logic signed [ACC_W-1:0] p0, p1, p2, acc, shifted;
  sample_t filt;

  // b1 = 2*b0 and b2 = b0 fold the feed-forward taps into one product
  assign tap_sum = SUM_W'(x) + (SUM_W'(x1) <<< 1) + SUM_W'(x2);

  assign b0_w  = ACC_W'(coef.b0);
  assign a1_w  = ACC_W'(coef.a1);
  assign a2_w  = ACC_W'(coef.a2);
  assign sum_w = ACC_W'(tap_sum);
  assign y1_w  = ACC_W'(y1);
  assign y2_w  = ACC_W'(y2);

  assign p0 = b0_w * sum_w;
  assign p1 = a1_w * y1_w;
  assign p2 = a2_w * y2_w;

  // round half up, then clamp to the sample range
  assign acc     = p0 - p1 - p2 + HALF;
  assign shifted = acc >>> COEF_FRAC_BITS;

  always_comb begin
    priority if (shifted > SAT_HI) begin
      filt = SAMPLE_BITS'(SAT_HI);
    end else if (shifted < SAT_LO) begin
      filt = SAMPLE_BITS'(SAT_LO);
    end else begin
      filt = SAMPLE_BITS'(shifted);
    end
  end

  assign y = pass ? x : filt;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (advance) begin
      x2 <= x1;
      x1 <= x;
      y2 <= y1;
      y1 <= y;
    end
  end

endmodule

FILE: sim/testbench.sv
// Self-checking bench for the six-axis IMU biquad low-pass block.
// Drives random and directed IMU words against an in-bench filter predictor;
// depends on imubq_pkg and imu_six_axis_biquad_lowpass.
`timescale 1ns / 100ps

module testbench;
  import imubq_pkg::*;

  typedef logic [NUM_AXES-1:0][SAMPLE_BITS-1:0] imu_word_t;

  localparam longint ROUND_HALF = longint'(1) << (COEF_FRAC_BITS - 1);
  localparam longint SAT_HI     = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO     = -SAT_HI - 1;
  localparam longint COEF_MAX   = (longint'(1) << (COEF_BITS - 1)) - 1;
  localparam longint COEF_MIN   = -COEF_MAX - 1;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  sample_t                  accel_x = '0, accel_y = '0, accel_z = '0;
  sample_t                  rate_x = '0, rate_y = '0, rate_z = '0;
  sample_t                  field_x = '0, field_y = '0, field_z = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  sample_t                  accel_x_out, accel_y_out, accel_z_out;
  sample_t                  rate_x_out, rate_y_out, rate_z_out;
  sample_t                  field_x_out, field_y_out, field_z_out;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  imu_six_axis_biquad_lowpass uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .rate_x      (rate_x),
    .rate_y      (rate_y),
    .rate_z      (rate_z),
    .field_x     (field_x),
    .field_y     (field_y),
    .field_z     (field_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accel_x_out (accel_x_out),
    .accel_y_out (accel_y_out),
    .accel_z_out (accel_z_out),
    .rate_x_out  (rate_x_out),
    .rate_y_out  (rate_y_out),
    .rate_z_out  (rate_z_out),
    .field_x_out (field_x_out),
    .field_y_out (field_y_out),
    .field_z_out (field_z_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #2 clk = ~clk;

  string axis_name [NUM_AXES] = '{"accel_x_out", "accel_y_out", "accel_z_out",
                                  "rate_x_out", "rate_y_out", "rate_z_out",
                                  "field_x_out", "field_y_out", "field_z_out"};

  // predictor copy of configuration and filter history
  coef_t                coef [6] = '{default: '0};
  logic [1:0]           bypass = 2'b11;
  logic [WARM_BITS-1:0] warm_len = '0;
  logic [WARM_BITS-1:0] warm_cnt = '0;
  sample_t              hist_x1 [FILTERED_AXES] = '{default: '0};
  sample_t              hist_x2 [FILTERED_AXES] = '{default: '0};
  sample_t              hist_y1 [FILTERED_AXES] = '{default: '0};
  sample_t              hist_y2 [FILTERED_AXES] = '{default: '0};

  imu_word_t raw_q [$];
  imu_word_t filtered_q [$];
  imu_word_t seen_word, want_word;
  longint    walk [NUM_AXES] = '{default: 0};

  int in_taken = 0, in_used = 0, in_wait = 0;
  int out_taken = 0, out_used = 0, out_wait = 0;
  bit quiet = 1'b0;
  int mismatch_count = 0;

  function automatic imu_word_t filter_sample(input imu_word_t raw);
    imu_word_t res;
    logic      warming;
    int        g;
    longint    acc, b0, a1, a2, xs, ys;
    warming = warm_cnt < warm_len;
    res = raw;
    for (int i = 0; i < FILTERED_AXES; i++) begin
      g = (i < GROUP_AXES) ? BYPASS_ACCEL : BYPASS_GYRO;
      xs = longint'($signed(raw[i]));
      ys = xs;
      if (!(warming || bypass[g])) begin
        b0 = coef[3*g];
        a1 = coef[3*g + 1];
        a2 = coef[3*g + 2];
        acc = b0 * xs + 2 * b0 * hist_x1[i] + b0 * hist_x2[i]
              - a1 * hist_y1[i] - a2 * hist_y2[i];
        // round half up: add half, then floor
        acc = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
        if (acc > SAT_HI) ys = SAT_HI;
        else if (acc < SAT_LO) ys = SAT_LO;
        else ys = acc;
      end
      hist_x2[i] = hist_x1[i];
      hist_x1[i] = xs[SAMPLE_BITS-1:0];
      hist_y2[i] = hist_y1[i];
      hist_y1[i] = ys[SAMPLE_BITS-1:0];
      res[i] = ys[SAMPLE_BITS-1:0];
    end
    if (warming) warm_cnt = warm_cnt + 1'b1;
    return res;
  endfunction

  // accept and check words at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        filtered_q.push_back(filter_sample({field_z, field_y, field_x, rate_z, rate_y,
                                            rate_x, accel_z, accel_y, accel_x}));
        in_taken++;
      end
      if (out_valid && out_ready) begin
        out_taken++;
        seen_word = {field_z_out, field_y_out, field_x_out, rate_z_out, rate_y_out,
                     rate_x_out, accel_z_out, accel_y_out, accel_x_out};
        if (filtered_q.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatch_count++;
        end else begin
          want_word = filtered_q.pop_front();
          for (int i = 0; i < NUM_AXES; i++) begin
            if (seen_word[i] !== want_word[i]) begin
              $error("%s: expected %0d, got %0d", axis_name[i],
                     $signed(want_word[i]), $signed(seen_word[i]));
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  // input driver: hold until accepted, then gap, then next word
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken != in_used)) begin
      in_used = in_taken;
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (raw_q.size() != 0) begin
        {field_z, field_y, field_x, rate_z, rate_y, rate_x,
         accel_z, accel_y, accel_x} <= raw_q.pop_front();
        in_valid <= 1'b1;
        in_wait = quiet ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: stall a drawn number of cycles before each word
  always @(negedge clk) begin
    if (out_taken != out_used) begin
      out_used = out_taken;
      out_wait = quiet ? 0 : $urandom_range(0, 13);
    end
    if (out_wait > 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input longint value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    case (idx)
      REG_BYPASS: bypass = value[1:0];
      REG_WARMUP: warm_len = value[WARM_BITS-1:0];
      default:    coef[idx] = value[COEF_BITS-1:0];
    endcase
    // every write clears history
    for (int i = 0; i < FILTERED_AXES; i++) begin
      hist_x1[i] = '0;
      hist_x2[i] = '0;
      hist_y1[i] = '0;
      hist_y2[i] = '0;
    end
    warm_cnt = '0;
  endtask

  task automatic load_config(input longint ab0, input longint aa1, input longint aa2,
                             input longint gb0, input longint ga1, input longint ga2,
                             input longint byp, input longint warm);
    write_reg(REG_ACCEL_B0, ab0);
    write_reg(REG_ACCEL_A1, aa1);
    write_reg(REG_ACCEL_A2, aa2);
    write_reg(REG_GYRO_B0, gb0);
    write_reg(REG_GYRO_A1, ga1);
    write_reg(REG_GYRO_A2, ga2);
    write_reg(REG_BYPASS, byp);
    write_reg(REG_WARMUP, warm);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every word is driven and every result has come back;
  // check at the rising edge, where the driver's queue and valid are settled
  task automatic drain();
    while (raw_q.size() != 0 || in_valid || filtered_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // kind 0: plausible low-pass, 1: anything, 2: corner values
  function automatic longint pick_coef(input int kind, input int role);
    if (kind == 0) begin
      if (role == 0) return longint'($urandom_range(1, 6000));
      if (role == 1) return -longint'($urandom_range(40000, 125000));
      return longint'($urandom_range(8000, 60000));
    end
    if (kind == 1) return longint'($urandom_range(0, 262143)) + COEF_MIN;
    case ($urandom_range(0, 5))
      0: return COEF_MIN;
      1: return COEF_MAX;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return 65536;
    endcase
    return 0;
  endfunction

  function automatic imu_word_t make_sample();
    imu_word_t w;
    int        style;
    style = $urandom_range(0, 9);
    for (int i = 0; i < NUM_AXES; i++) begin
      if (style < 5) begin
        // smooth sensor-like drift
        walk[i] = walk[i] + longint'($urandom_range(0, 4000)) - 2000;
        if (walk[i] > SAT_HI) walk[i] = SAT_HI;
        else if (walk[i] < SAT_LO) walk[i] = SAT_LO;
        w[i] = walk[i][SAMPLE_BITS-1:0];
      end else if (style < 7) begin
        w[i] = SAMPLE_BITS'($urandom_range(0, 65535));
      end else if (style < 9) begin
        w[i] = SAMPLE_BITS'($urandom_range(0, 600) - 300);
      end else begin
        case ($urandom_range(0, 3))
          0: w[i] = 16'h8000;
          1: w[i] = 16'h7fff;
          2: w[i] = 16'h0000;
          default: w[i] = 16'hffff;
        endcase
      end
    end
    return w;
  endfunction

  task automatic random_setup();
    int     ka, kg, r;
    longint byp, warm;
    ka = $urandom_range(0, 3);
    kg = $urandom_range(0, 3);
    ka = (ka < 2) ? 0 : ka - 1;
    kg = (kg < 2) ? 0 : kg - 1;
    r = $urandom_range(0, 9);
    byp = (r < 5) ? 0 : $urandom_range(1, 3);
    r = $urandom_range(0, 9);
    if (r < 4) warm = 0;
    else if (r < 8) warm = $urandom_range(1, 12);
    else if (r < 9) warm = $urandom_range(0, 65535);
    else warm = 65535;
    load_config(pick_coef(ka, 0), pick_coef(ka, 1), pick_coef(ka, 2),
                pick_coef(kg, 0), pick_coef(kg, 1), pick_coef(kg, 2), byp, warm);
  endtask

  initial begin
    int phase, n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: both groups bypassed
    raw_q.push_back({NUM_AXES{16'h8000}});
    raw_q.push_back({NUM_AXES{16'h7fff}});
    raw_q.push_back({NUM_AXES{16'h0000}});
    raw_q.push_back({NUM_AXES{16'hffff}});
    raw_q.push_back({NUM_AXES{16'h5a5a}});
    drain();

    // corner coefficients, drive into saturation both ways
    load_config(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, 0, 0);
    repeat (3) raw_q.push_back({NUM_AXES{16'h7fff}});
    repeat (3) raw_q.push_back({NUM_AXES{16'h8000}});
    drain();

    // plausible low-pass, accel bypassed, three warm-up words
    load_config(4000, -74901, 27054, 4000, -74901, 27054, 1, 3);
    repeat (5) raw_q.push_back(make_sample());
    drain();

    // half gain exposes rounding ties, gyro bypassed
    load_config(32768, 0, 0, 32768, 0, 0, 2, 0);
    raw_q.push_back({NUM_AXES{16'h0001}});
    raw_q.push_back({NUM_AXES{16'hffff}});
    raw_q.push_back({NUM_AXES{16'h0003}});
    raw_q.push_back({NUM_AXES{16'hfffd}});
    drain();

    // longest warm-up
    load_config(4000, -74901, 27054, 2000, -100000, 40000, 0, 65535);
    repeat (2) raw_q.push_back(make_sample());
    drain();

    for (phase = 0; phase < 12; phase++) begin
      quiet = (phase % 4 == 3);
      random_setup();
      for (n = 0; n < 95; n++) raw_q.push_back(make_sample());
      drain();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/imubq_pkg.sv
rtl/imubq_cfg.sv
rtl/imubq_lane.sv
rtl/imu_six_axis_biquad_lowpass.sv
sim/testbench.sv
